>>> src/deq_pkg.sv
// Package for the double-ended queue: payload structs, operation and status codes,
// controller state and the command/status structs between controller and datapath.
// No dependencies.
package deq_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int VALUE_W        = 32;
   localparam int LEN_W          = 7;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [VALUE_W-1:0]  push_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  pop_value;
      status_type                 status;
      logic [LEN_W-1:0]           length;
      logic                       is_empty;
   } rsp_payload_type;

   typedef enum logic {
      CS_IDLE   = 1'b0,
      CS_FINISH = 1'b1
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;   // operation accepted: update pointers, issue RAM access
      logic load;    // move the pending result into the output register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;  // output register empty or draining this cycle
   } dp_stat_type;

endpackage

>>> src/deq_chan_if.sv
// Valid/ready channel interface carrying one payload struct per transfer.
// Payload type comes in as a type parameter (see deq_pkg).
interface deq_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/double_ended_queue.sv
// Top level of the bounded double-ended queue (ring buffer in a RAM).
// Depends on deq_pkg, deq_chan_if, deq_ctrl, deq_dp and deq_ram.
//
//  channel   direction  payload                                   transfer when
//  req_if    in         kind, push_value                          req_if.valid && req_if.ready
//  rsp_if    out        pop_value, status, length, is_empty       rsp_if.valid && rsp_if.ready
//
// Each operation runs as an accept step and a finish step: the accept step updates
// head and count and issues the RAM access, the finish step moves the registered RAM
// read data and status into the output register. One operation is in flight at a time.
// A result waits in the output register while the next request is accepted;
// the finish step stalls only while that register is still occupied.
// Reset (synchronous) empties the queue; RAM contents are not cleared.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   deq_chan_if.sink   req_if,
   deq_chan_if.source rsp_if
);

   dp_cmd_type      cmd;
   dp_stat_type     stat;
   logic            req_ready;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;
   req_payload_type req_payload;

   assign req_payload = req_if.payload;

   // sequencing: accept, then finish into the output register
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // pointers, entry RAM and result register
   deq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // drive the channel ports
   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_payload;

endmodule

>>> src/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/deq_ctrl.sv
// Controller for the double-ended queue: accepts one request, then waits for the
// output register before returning to idle. Uses deq_pkg.
module deq_ctrl import deq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            // hold off while reset is asserted so that no transfer is dropped
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.start = 1'b1;
               state_in  = CS_FINISH;
            end
         end
         CS_FINISH: begin
            // hold until the output register can take the result
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in flight");

endmodule

>>> src/deq_dp.sv
// Datapath for the double-ended queue: head and count registers, ring index
// arithmetic, entry RAM and the output register. Uses deq_pkg and deq_ram.
module deq_dp import deq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      cmd,
   output dp_stat_type     stat,
   input  req_payload_type req_payload,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = $clog2(2 * DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop_ok_ff, pop_ok_in;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic                  is_full;
   logic                  is_empty_now;
   logic [IDX_W-1:0]      head_dec;
   logic [IDX_W-1:0]      head_inc;
   logic [SUM_W-1:0]      back_sum;
   logic [SUM_W-1:0]      last_sum;
   logic [SUM_W-1:0]      back_free;
   logic [SUM_W-1:0]      back_last;
   logic [63:0]           push_wide;
   logic [63:0]           pop_wide;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   assign is_full      = (count_ff == FULL_CNT);
   assign is_empty_now = (count_ff == '0);
   assign head_dec     = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_inc     = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;

   // back positions wrap by one compare and subtract: the sums stay below 2*DEPTH
   assign back_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign last_sum  = back_sum - 1'b1;
   assign back_free = (back_sum >= DEPTH_SUM) ? back_sum - DEPTH_SUM : back_sum;
   assign back_last = (last_sum >= DEPTH_SUM) ? last_sum - DEPTH_SUM : last_sum;

   assign push_wide = 64'($unsigned(req_payload.push_value));
   assign wr_data   = push_wide[DATA_WIDTH-1:0];

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      pop_ok_in = pop_ok_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      if (cmd.start) begin
         pop_ok_in = 1'b0;
         status_in = ST_OK;
         case (req_payload.kind)
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  head_in  = head_dec;
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = back_free[IDX_W-1:0];
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (is_empty_now) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = head_ff;
                  head_in   = head_inc;
                  count_in  = count_ff - 1'b1;
                  pop_ok_in = 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (is_empty_now) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = back_last[IDX_W-1:0];
                  count_in  = count_ff - 1'b1;
                  pop_ok_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pop_wide = 64'(rd_data);

   // output register: load on command, drop after the transfer
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.load) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.pop_value = pop_ok_ff ? $signed(pop_wide[VALUE_W-1:0]) : '0;
         rsp_payload_in.status    = status_ff;
         rsp_payload_in.length    = LEN_W'(count_ff);
         rsp_payload_in.is_empty  = is_empty_now;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pop_ok_ff      <= pop_ok_in;
      status_ff      <= status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_payload_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("element count beyond depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_IDX)
      else $error("head index outside the ring");

   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && is_full &&
       (req_payload.kind == OP_PUSH_FRONT || req_payload.kind == OP_PUSH_BACK))
      |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("push on a full queue changed the state");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load))
      else $error("result raised without a load");

endmodule

>>> dv/tb_top.sv
// Testbench for the double-ended queue: random and directed push/pop traffic
// checked against a ring-buffer predictor of its own.
// Depends on deq_pkg, deq_chan_if and double_ended_queue.
`timescale 1ns / 1ps

module tb_top;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEF;
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int RANDOM_OPS  = 1880;
   localparam int HOLD_AT     = 2000;      // cycle at which the long back-pressure starts
   localparam int HOLD_LEN    = 600;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 20;

   logic clock;
   logic reset;

   deq_chan_if #(.payload_type(req_payload_type)) req_ch ();
   deq_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   double_ended_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predictor state: a ring of slots with a front index and an occupancy count
   logic signed [VALUE_W-1:0] model_slots [QUEUE_DEPTH];
   logic [SLOT_W-1:0]         model_head;
   logic [LEN_W-1:0]          model_count;

   req_payload_type pending_ops [$];     // operations still to be offered
   rsp_payload_type expected_rsps [$];   // predicted results, oldest first

   int  error_count = 0;
   int  cycle_count;
   int  hold_left;
   int  req_gap;
   int  rsp_gap;
   bit  calm;      // set for stretches in which neither side idles

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one operation to the predictor and return the result it causes.
   // A pop only ever reads a slot that a push wrote, so nothing undefined is read.
   function automatic rsp_payload_type apply_deque_op(req_payload_type op);
      rsp_payload_type   res;
      logic [SLOT_W-1:0] slot;
      res.pop_value = '0;
      res.status    = ST_OK;
      case (op.kind) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (model_count == LEN_W'(QUEUE_DEPTH)) begin
               res.status = ST_FULL;
            end else if (op.kind == OP_PUSH_FRONT) begin
               model_head              = model_head - 1'b1;
               model_slots[model_head] = op.push_value;
               model_count             = model_count + 1'b1;
            end else begin
               slot              = model_head + SLOT_W'(model_count);
               model_slots[slot] = op.push_value;
               model_count       = model_count + 1'b1;
            end
         end
         default: begin
            if (model_count == '0) begin
               res.status = ST_EMPTY;
            end else if (op.kind == OP_POP_FRONT) begin
               res.pop_value = model_slots[model_head];
               model_head    = model_head + 1'b1;
               model_count   = model_count - 1'b1;
            end else begin
               slot          = model_head + SLOT_W'(model_count) - 1'b1;
               res.pop_value = model_slots[slot];
               model_count   = model_count - 1'b1;
            end
         end
      endcase
      res.length   = model_count;
      res.is_empty = (model_count == '0);
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long; none while calm
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Push value: extremes now and then, otherwise any 32-bit pattern
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type make_op(kind_type k, logic signed [VALUE_W-1:0] v);
      req_payload_type op;
      op.kind       = k;
      op.push_value = v;
      return op;
   endfunction

   // Cycle count, long receiver hold-off, calm stretches and the timeout
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
         hold_left   <= 0;
         calm        <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         // Hold the result side off long enough for the block to stall its input
         if (cycle_count == HOLD_AT)
            hold_left <= HOLD_LEN;
         else if (hold_left != 0)
            hold_left <= hold_left - 1;
         // Re-pick the calm flag whenever the low eight bits of the cycle count are zero
         if (cycle_count[7:0] == 8'd0)
            calm <= ($urandom_range(0, 3) == 0);
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Request driver: predict on each transfer, then offer the next operation
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.payload <= '0;
         req_gap        <= 0;
         model_head     <= '0;
         model_count    <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_rsps.push_back(apply_deque_op(req_ch.payload));
         // Hold the current offer until it transfers
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap != 0) begin
               req_gap      <= req_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               req_ch.payload <= pending_ops.pop_front();
               req_ch.valid   <= 1'b1;
               req_gap        <= pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap      <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result: pop_value %0d status %0d length %0d",
                      rsp_ch.payload.pop_value, rsp_ch.payload.status,
                      rsp_ch.payload.length);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ch.payload.pop_value !== want.pop_value) begin
                  $error("pop_value: expected %0d, got %0d",
                         want.pop_value, rsp_ch.payload.pop_value);
                  error_count++;
               end
               if (rsp_ch.payload.status !== want.status) begin
                  $error("status: expected %s, got %0d",
                         want.status.name(), rsp_ch.payload.status);
                  error_count++;
               end
               if (rsp_ch.payload.length !== want.length) begin
                  $error("length: expected %0d, got %0d",
                         want.length, rsp_ch.payload.length);
                  error_count++;
               end
               if (rsp_ch.payload.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0b, got %0b",
                         want.is_empty, rsp_ch.payload.is_empty);
                  error_count++;
               end
            end
         end
         // Drop ready during the long hold-off and the random stalls
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_gap      <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_gap      <= pick_gap();
         end
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      int left;
      int burst;
      int push_pct;
      int n;
      kind_type k;

      reset = 1'b1;

      // Directed: pops on empty from both ends, extreme values at both ends,
      // pops from both ends, and a front push that wraps the head below zero
      pending_ops.push_back(make_op(OP_POP_FRONT,  '0));
      pending_ops.push_back(make_op(OP_POP_BACK,   32'sh7FFF_FFFF));
      pending_ops.push_back(make_op(OP_PUSH_BACK,  32'sh7FFF_FFFF));
      pending_ops.push_back(make_op(OP_PUSH_FRONT, 32'sh8000_0000));
      pending_ops.push_back(make_op(OP_PUSH_BACK,  -32'sd1));
      pending_ops.push_back(make_op(OP_PUSH_FRONT, '0));
      pending_ops.push_back(make_op(OP_POP_BACK,   -32'sd1));
      pending_ops.push_back(make_op(OP_POP_FRONT,  '0));
      pending_ops.push_back(make_op(OP_POP_FRONT,  '0));
      pending_ops.push_back(make_op(OP_POP_BACK,   '0));
      pending_ops.push_back(make_op(OP_POP_BACK,   '0));
      pending_ops.push_back(make_op(OP_PUSH_FRONT, 32'sd1));
      pending_ops.push_back(make_op(OP_PUSH_FRONT, 32'sd2));
      pending_ops.push_back(make_op(OP_POP_BACK,   '0));
      pending_ops.push_back(make_op(OP_PUSH_BACK,  32'sh5555_AAAA));
      pending_ops.push_back(make_op(OP_POP_FRONT,  '0));
      pending_ops.push_back(make_op(OP_POP_FRONT,  '0));
      pending_ops.push_back(make_op(OP_POP_FRONT,  '0));

      // Random bursts, each with its own push bias, so the queue fills to the
      // brim, sees pushes while full, drains to empty and wanders in between.
      // The first two bursts force one full fill and one full drain.
      left  = RANDOM_OPS;
      burst = 0;
      while (left > 0) begin
         if (burst == 0) begin
            n        = 110;
            push_pct = 95;
         end else if (burst == 1) begin
            n        = 110;
            push_pct = 5;
         end else begin
            n = $urandom_range(16, 128);
            case ($urandom_range(0, 4))
               0:       push_pct = 90;
               1:       push_pct = 70;
               2:       push_pct = 50;
               3:       push_pct = 30;
               default: push_pct = 10;
            endcase
         end
         if (n > left) n = left;
         repeat (n) begin
            if ($urandom_range(0, 99) < push_pct)
               k = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
               k = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            pending_ops.push_back(make_op(k, pick_value()));
         end
         left  -= n;
         burst += 1;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait, away from the active edge, until every operation has transferred
      // and every prediction has been matched
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
